// ===== rtl/cbct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the change-code function of the CAN byte change tracker.
// No dependencies; every other file of the block imports this package.
package cbct_pkg;

   localparam int PAYLOAD_BYTES_DEFAULT = 8;
   localparam int FIELD_BYTES           = 8;

   localparam int OP_W      = 2;
   localparam int DATA_W    = 64;
   localparam int DLEN_W    = 4;
   localparam int SEQ_W     = 32;
   localparam int TIME_W    = 48;
   localparam int QIDX_W    = 3;
   localparam int CODES_W   = 16;

   localparam logic [OP_W-1:0] OP_FRAME       = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK        = 2'd1;
   localparam logic [OP_W-1:0] OP_NOTCH_ADD   = 2'd2;
   localparam logic [OP_W-1:0] OP_NOTCH_CLEAR = 2'd3;

   localparam logic [1:0] CODE_NONE = 2'd0;
   localparam logic [1:0] CODE_UP   = 2'd1;
   localparam logic [1:0] CODE_DOWN = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [DATA_W-1:0] frame_data;
      logic [DLEN_W-1:0] data_len;
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] time_us;
      logic [QIDX_W-1:0] query_index;
   } cbct_item_type;

   function automatic logic [1:0] change_code(input logic [7:0] now_byte,
                                              input logic [7:0] last_byte,
                                              input logic [7:0] notch,
                                              input logic [7:0] last_marker);
      logic [7:0] a;
      logic [7:0] b;
      logic [1:0] code;
      a = now_byte & ~notch;
      b = last_byte & ~notch;
      if (last_marker == 8'h00) begin
         code = CODE_NONE;
      end else if (notch != 8'h00 && (a == 8'h00 || a == b)) begin
         code = CODE_NONE;
      end else if (a >= b) begin
         code = CODE_UP;
      end else begin
         code = CODE_DOWN;
      end
      return code;
   endfunction

endpackage

// ===== rtl/cbct_state.sv =====
`timescale 1ns / 1ps
// Tracker state registers and their next-state logic for all four operations.
// Depends on cbct_pkg; the next-state values feed cbct_report.
module cbct_state
   import cbct_pkg::*;
#(
   parameter int PayloadBytes = PAYLOAD_BYTES_DEFAULT,
   parameter int LenW         = $clog2(PayloadBytes + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           update,
   input  cbct_item_type                  item,
   input  logic                           mute_notched,
   output logic [PayloadBytes-1:0][7:0]   cur_bytes_in,
   output logic [PayloadBytes-1:0][7:0]   last_bytes_in,
   output logic [PayloadBytes-1:0][SEQ_W-1:0] stamps_in,
   output logic [PayloadBytes-1:0][7:0]   last_marker_in,
   output logic [PayloadBytes-1:0][7:0]   notch_in,
   output logic [LenW-1:0]                cur_len_in,
   output logic [TIME_W-1:0]              cur_time_in,
   output logic [TIME_W-1:0]              prev_time_in,
   output logic [SEQ_W-1:0]               cur_seq_in
);

   logic [PayloadBytes-1:0][7:0]       cur_bytes_ff;
   logic [PayloadBytes-1:0][7:0]       last_bytes_ff;
   logic [PayloadBytes-1:0][SEQ_W-1:0] stamps_ff;
   logic [PayloadBytes-1:0][7:0]       marker_ff;
   logic [PayloadBytes-1:0][7:0]       marker_in;
   logic [PayloadBytes-1:0][7:0]       last_marker_ff;
   logic [PayloadBytes-1:0][7:0]       notch_ff;
   logic [LenW-1:0]                    cur_len_ff;
   logic [TIME_W-1:0]                  cur_time_ff;
   logic [TIME_W-1:0]                  prev_time_ff;
   logic [SEQ_W-1:0]                   cur_seq_ff;
   logic                               seen_first_ff;
   logic                               seen_first_in;

   logic [PayloadBytes-1:0][7:0]       fresh;
   logic [LenW-1:0]                    frame_len;

   for (genvar g = 0; g < PayloadBytes; g++) begin : g_fresh
      if (g < FIELD_BYTES) begin : g_field
         assign fresh[g] = item.frame_data[8*g +: 8];
      end else begin : g_zero
         assign fresh[g] = 8'h00;
      end
   end

   always_comb begin
      if (int'(item.data_len) > PayloadBytes) begin
         frame_len = LenW'(PayloadBytes);
      end else begin
         frame_len = LenW'(item.data_len);
      end
   end

   always_comb begin
      cur_bytes_in   = cur_bytes_ff;
      last_bytes_in  = last_bytes_ff;
      stamps_in      = stamps_ff;
      marker_in      = marker_ff;
      last_marker_in = last_marker_ff;
      notch_in       = notch_ff;
      cur_len_in     = cur_len_ff;
      cur_time_in    = cur_time_ff;
      prev_time_in   = prev_time_ff;
      cur_seq_in     = cur_seq_ff;
      seen_first_in  = seen_first_ff;
      case (item.operation)
         OP_FRAME: begin
            cur_len_in    = frame_len;
            cur_time_in   = item.time_us;
            cur_seq_in    = item.seq;
            seen_first_in = 1'b1;
            if (!seen_first_ff) begin
               for (int i = 0; i < PayloadBytes; i++) begin
                  if (i < int'(frame_len)) begin
                     cur_bytes_in[i] = fresh[i];
                     stamps_in[i]    = item.seq;
                  end
               end
               last_bytes_in  = cur_bytes_in;
               marker_in      = '0;
               last_marker_in = '0;
               notch_in       = '0;
               prev_time_in   = item.time_us;
            end else begin
               last_bytes_in = cur_bytes_ff;
               prev_time_in  = cur_time_ff;
               for (int i = 0; i < PayloadBytes; i++) begin
                  if (i < int'(frame_len) &&
                      ((fresh[i] ^ cur_bytes_ff[i]) &
                       (mute_notched ? ~notch_ff[i] : 8'hFF)) != 8'h00) begin
                     cur_bytes_in[i] = fresh[i];
                     stamps_in[i]    = item.seq;
                  end
                  marker_in[i] = marker_ff[i] | (cur_bytes_ff[i] ^ cur_bytes_in[i]);
               end
            end
         end
         OP_TICK: begin
            last_marker_in = marker_ff;
            marker_in      = '0;
         end
         OP_NOTCH_ADD: begin
            notch_in = notch_ff | last_marker_ff;
         end
         OP_NOTCH_CLEAR: begin
            notch_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bytes_ff   <= '0;
         last_bytes_ff  <= '0;
         stamps_ff      <= '0;
         marker_ff      <= '0;
         last_marker_ff <= '0;
         notch_ff       <= '0;
         cur_len_ff     <= '0;
         cur_time_ff    <= '0;
         prev_time_ff   <= '0;
         cur_seq_ff     <= '0;
         seen_first_ff  <= 1'b0;
      end else if (update) begin
         cur_bytes_ff   <= cur_bytes_in;
         last_bytes_ff  <= last_bytes_in;
         stamps_ff      <= stamps_in;
         marker_ff      <= marker_in;
         last_marker_ff <= last_marker_in;
         notch_ff       <= notch_in;
         cur_len_ff     <= cur_len_in;
         cur_time_ff    <= cur_time_in;
         prev_time_ff   <= prev_time_in;
         cur_seq_ff     <= cur_seq_in;
         seen_first_ff  <= seen_first_in;
      end
   end

endmodule

// ===== rtl/cbct_report.sv =====
`timescale 1ns / 1ps
// Result formatting: payload, change codes, notch masks, time delta, sequence interval.
// Depends on cbct_pkg; reads the next-state values from cbct_state.
module cbct_report
   import cbct_pkg::*;
#(
   parameter int PayloadBytes = PAYLOAD_BYTES_DEFAULT,
   parameter int LenW         = $clog2(PayloadBytes + 1)
) (
   input  logic [PayloadBytes-1:0][7:0]       cur_bytes,
   input  logic [PayloadBytes-1:0][7:0]       last_bytes,
   input  logic [PayloadBytes-1:0][SEQ_W-1:0] stamps,
   input  logic [PayloadBytes-1:0][7:0]       last_marker,
   input  logic [PayloadBytes-1:0][7:0]       notch,
   input  logic [LenW-1:0]                    cur_len,
   input  logic [TIME_W-1:0]                  cur_time,
   input  logic [TIME_W-1:0]                  prev_time,
   input  logic [SEQ_W-1:0]                   cur_seq,
   input  logic [QIDX_W-1:0]                  query_index,
   output logic [DATA_W-1:0]                  payload,
   output logic [DLEN_W-1:0]                  payload_len,
   output logic [CODES_W-1:0]                 change_codes,
   output logic [DATA_W-1:0]                  notch_masks,
   output logic [TIME_W-1:0]                  delta_us,
   output logic [SEQ_W-1:0]                   seq_interval
);

   localparam int OutBytes = (PayloadBytes < FIELD_BYTES) ? PayloadBytes : FIELD_BYTES;

   logic [SEQ_W-1:0] stamp;

   always_comb begin
      payload      = '0;
      notch_masks  = '0;
      change_codes = '0;
      stamp        = '0;
      for (int i = 0; i < OutBytes; i++) begin
         notch_masks[8*i +: 8] = notch[i];
         if (i < int'(cur_len)) begin
            payload[8*i +: 8]      = cur_bytes[i];
            change_codes[2*i +: 2] = change_code(cur_bytes[i], last_bytes[i],
                                                 notch[i], last_marker[i]);
            if (i == int'(query_index)) begin
               stamp = stamps[i];
            end
         end
      end
   end

   assign payload_len  = DLEN_W'(cur_len);
   assign delta_us     = cur_time - prev_time;
   assign seq_interval = cur_seq - stamp;

endmodule

// ===== rtl/can_byte_change_tracker_core.sv =====
`timescale 1ns / 1ps
// Top level of the CAN byte change tracker: input register, state update, result register.
// Depends on cbct_pkg, cbct_state and cbct_report.
//
// Usage:
//   Request channel (req_*): one transaction per operation - frame, marker tick,
//   notch add or notch clear. Frame fields matter only for a frame.
//   Response channel (rsp_*): exactly one transaction per request, in order,
//   describing the tracker state after that operation.
//   csr_wr_en / csr_wr_data set the mute-notched bit; write it only while idle.
//   Timing: a taken request is held in the input register; its result is computed
//   from it and captured in the result register as it advances, raising rsp_valid.
//   Throughput: one transaction per cycle unless rsp_stall holds a full result
//   register; state and result logic are combinational between the two registers.
//   Stall: while rsp_stall holds a full result register, the input register
//   holds its transaction and req_stall rises once it is occupied.
//   Reset: synchronous; clears the tracked state, the mute bit and both
//   pipeline valid flags. The first frame after reset initializes the payload.
module can_byte_change_tracker_core
   import cbct_pkg::*;
#(
   parameter int PayloadBytes = PAYLOAD_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [DATA_W-1:0]  req_frame_data,
   input  logic [DLEN_W-1:0]  req_data_len,
   input  logic [SEQ_W-1:0]   req_seq,
   input  logic [TIME_W-1:0]  req_time_us,
   input  logic [QIDX_W-1:0]  req_query_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_payload,
   output logic [DLEN_W-1:0]  rsp_payload_len,
   output logic [CODES_W-1:0] rsp_change_codes,
   output logic [DATA_W-1:0]  rsp_notch_masks,
   output logic [TIME_W-1:0]  rsp_delta_us,
   output logic [SEQ_W-1:0]   rsp_seq_interval,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   localparam int LenW = $clog2(PayloadBytes + 1);

   cbct_item_type item_ff;
   logic          item_valid_ff;
   logic          item_valid_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          mute_ff;
   logic          accept;
   logic          advance;

   logic [PayloadBytes-1:0][7:0]       cur_bytes_in;
   logic [PayloadBytes-1:0][7:0]       last_bytes_in;
   logic [PayloadBytes-1:0][SEQ_W-1:0] stamps_in;
   logic [PayloadBytes-1:0][7:0]       last_marker_in;
   logic [PayloadBytes-1:0][7:0]       notch_in;
   logic [LenW-1:0]                    cur_len_in;
   logic [TIME_W-1:0]                  cur_time_in;
   logic [TIME_W-1:0]                  prev_time_in;
   logic [SEQ_W-1:0]                   cur_seq_in;

   logic [DATA_W-1:0]  payload_in;
   logic [DLEN_W-1:0]  payload_len_in;
   logic [CODES_W-1:0] change_codes_in;
   logic [DATA_W-1:0]  notch_masks_in;
   logic [TIME_W-1:0]  delta_us_in;
   logic [SEQ_W-1:0]   seq_interval_in;

   logic [DATA_W-1:0]  payload_ff;
   logic [DLEN_W-1:0]  payload_len_ff;
   logic [CODES_W-1:0] change_codes_ff;
   logic [DATA_W-1:0]  notch_masks_ff;
   logic [TIME_W-1:0]  delta_us_ff;
   logic [SEQ_W-1:0]   seq_interval_ff;

   assign advance       = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = item_valid_ff && !advance;
   assign accept        = req_valid && !req_stall;
   assign item_valid_in = accept || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mute_ff       <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            mute_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.operation   <= req_operation;
         item_ff.frame_data  <= req_frame_data;
         item_ff.data_len    <= req_data_len;
         item_ff.seq         <= req_seq;
         item_ff.time_us     <= req_time_us;
         item_ff.query_index <= req_query_index;
      end
   end

   cbct_state #(
      .PayloadBytes (PayloadBytes),
      .LenW         (LenW)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .update         (advance),
      .item           (item_ff),
      .mute_notched   (mute_ff),
      .cur_bytes_in   (cur_bytes_in),
      .last_bytes_in  (last_bytes_in),
      .stamps_in      (stamps_in),
      .last_marker_in (last_marker_in),
      .notch_in       (notch_in),
      .cur_len_in     (cur_len_in),
      .cur_time_in    (cur_time_in),
      .prev_time_in   (prev_time_in),
      .cur_seq_in     (cur_seq_in)
   );

   cbct_report #(
      .PayloadBytes (PayloadBytes),
      .LenW         (LenW)
   ) u_report (
      .cur_bytes    (cur_bytes_in),
      .last_bytes   (last_bytes_in),
      .stamps       (stamps_in),
      .last_marker  (last_marker_in),
      .notch        (notch_in),
      .cur_len      (cur_len_in),
      .cur_time     (cur_time_in),
      .prev_time    (prev_time_in),
      .cur_seq      (cur_seq_in),
      .query_index  (item_ff.query_index),
      .payload      (payload_in),
      .payload_len  (payload_len_in),
      .change_codes (change_codes_in),
      .notch_masks  (notch_masks_in),
      .delta_us     (delta_us_in),
      .seq_interval (seq_interval_in)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_ff      <= payload_in;
         payload_len_ff  <= payload_len_in;
         change_codes_ff <= change_codes_in;
         notch_masks_ff  <= notch_masks_in;
         delta_us_ff     <= delta_us_in;
         seq_interval_ff <= seq_interval_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = payload_ff;
   assign rsp_payload_len  = payload_len_ff;
   assign rsp_change_codes = change_codes_ff;
   assign rsp_notch_masks  = notch_masks_ff;
   assign rsp_delta_us     = delta_us_ff;
   assign rsp_seq_interval = seq_interval_ff;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && rsp_valid_ff && rsp_stall |=> item_valid_ff)
      else $error("input register dropped a blocked transaction");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced transaction produced no result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipeline");

   a_codes_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_change_codes & (rsp_change_codes >> 1)) & 16'h5555) == 16'h0000)
      else $error("illegal change code");

endmodule
